[rtl/sfd_pkg.sv]
// Shared types and constants for the serial frame deframer.
`timescale 1ns / 1ps

package sfd_pkg;

    typedef logic [2:0] t_role;

    localparam t_role ROLE_LEN     = 3'd0;
    localparam t_role ROLE_CMD0    = 3'd1;
    localparam t_role ROLE_CMD1    = 3'd2;
    localparam t_role ROLE_PAYLOAD = 3'd3;
    localparam t_role ROLE_CHECK   = 3'd4;

    localparam logic [7:0] START_BYTE_RST = 8'hFE;

    typedef struct packed {
        logic [7:0] byte_value;
        t_role      byte_role;
        logic [7:0] payload_index;
        logic       frame_end;
        logic       frame_good;
    } t_result;

endpackage

[rtl/sfd_if.sv]
// Channel interfaces for received bytes, tagged result items and configuration writes.
`timescale 1ns / 1ps

interface sfd_in_if;
    import sfd_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
    import sfd_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    t_role      byte_role;
    logic [7:0] payload_index;
    logic       frame_end;
    logic       frame_good;

    modport source (output valid, output byte_value, output byte_role, output payload_index,
                    output frame_end, output frame_good, input ready);
    modport sink   (input valid, input byte_value, input byte_role, input payload_index,
                    input frame_end, input frame_good, output ready);
endinterface

interface sfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/serial_frame_deframer.sv]
// Top level of the serial frame deframer: input register, parser and result register.
`timescale 1ns / 1ps

// Usage:
// Received bytes enter on i_in (valid/ready, field rx_byte). While hunting, a byte equal
// to the start byte register opens a frame and gives no item; any other byte is dropped.
// Inside a frame every byte leaves on o_out as one item tagged with its role (length,
// first command, second command, payload, check byte) and, for payload bytes, its index.
// The check byte item carries frame_end and frame_good, the latter set when the byte
// equals the XOR of length, command and payload bytes.
// The start byte register is written through i_cfg; it resets to 0xFE and should only be
// written while no item is in flight.
// An accepted item passes from the input register through the parser into the result
// register, which presents it on o_out.
// Throughput: one byte per cycle while the receiver takes items, set by the combinational
// parser between the input register and the result register.
// When the receiver stalls, the result register holds its item and the input register
// still takes one more byte; further bytes wait until the result register frees up.
// Bytes that produce no item never wait on the output side.
// Reset clears both register valid flags, returns the parser to hunting and restores
// the start byte to 0xFE.

module serial_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfd_in_if.sink      i_in,
    sfd_out_if.source   o_out,
    sfd_cfg_if.sink     i_cfg
);
    import sfd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic [7:0] r_start_byte;

    logic       has_result;
    t_result    result;
    logic       out_free;
    logic       s1_fire;

    // The result register can take a new item when empty or being emptied this cycle.
    assign out_free   = !r_out_valid || o_out.ready;
    // A byte with no item leaves the input register regardless of the output side.
    assign s1_fire    = r_in_valid && (!has_result || out_free);
    assign i_in.ready = !r_in_valid || s1_fire;
    assign i_cfg.ready = 1'b1;

    sfd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (s1_fire),
        .i_byte       (r_in_byte),
        .i_start_byte (r_start_byte),
        .o_has_result (has_result),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
        end else if (i_cfg.valid) begin
            r_start_byte <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (s1_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && has_result) begin
            r_out <= result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.byte_value    = r_out.byte_value;
    assign o_out.byte_role     = r_out.byte_role;
    assign o_out.payload_index = r_out.payload_index;
    assign o_out.frame_end     = r_out.frame_end;
    assign o_out.frame_good    = r_out.frame_good;

`ifndef ASSERT_OFF
    // The result register never loads while it holds an item the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !(s1_fire && has_result))
        else $error("result register overwritten while stalled");

    // Frame end comes only with the check byte role.
    a_end_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_end) |-> (r_out.byte_role == ROLE_CHECK))
        else $error("frame end on a byte that is not the check byte");

    // A good flag is only meaningful on a frame end.
    a_good_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_good) |-> r_out.frame_end)
        else $error("frame good without frame end");

    // Payload index is zero for every role other than payload.
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.byte_role != ROLE_PAYLOAD)) |-> (r_out.payload_index == 8'd0))
        else $error("payload index set on a non-payload byte");
`endif

endmodule

[rtl/sfd_parser.sv]
// Frame parsing state machine: tags each byte of a frame and tracks the XOR check.
`timescale 1ns / 1ps

module sfd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_start_byte,
    output logic             o_has_result,
    output sfd_pkg::t_result o_result
);
    import sfd_pkg::*;

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_CMD0    = 3'd2;
    localparam logic [2:0] PH_CMD1    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CHECK   = 3'd5;

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_len, n_len;
    logic [7:0] r_count, n_count;
    logic [7:0] r_check, n_check;
    logic [7:0] count_inc;

    assign count_inc = r_count + 8'd1;

    always_comb begin
        n_phase      = r_phase;
        n_len        = r_len;
        n_count      = r_count;
        n_check      = r_check;
        o_has_result = 1'b1;
        o_result     = '{byte_value: i_byte, byte_role: ROLE_LEN, payload_index: 8'd0,
                         frame_end: 1'b0, frame_good: 1'b0};
        unique case (r_phase)
            PH_LEN: begin
                n_len   = i_byte;
                n_check = i_byte;
                n_count = 8'd0;
                n_phase = PH_CMD0;
            end
            PH_CMD0: begin
                n_check            = r_check ^ i_byte;
                n_phase            = PH_CMD1;
                o_result.byte_role = ROLE_CMD0;
            end
            PH_CMD1: begin
                n_check            = r_check ^ i_byte;
                n_phase            = (r_len != 8'd0) ? PH_PAYLOAD : PH_CHECK;
                o_result.byte_role = ROLE_CMD1;
            end
            PH_PAYLOAD: begin
                n_check                = r_check ^ i_byte;
                o_result.byte_role     = ROLE_PAYLOAD;
                o_result.payload_index = r_count;
                if (count_inc == r_len) begin
                    n_count = 8'd0;
                    n_phase = PH_CHECK;
                end else begin
                    n_count = count_inc;
                end
            end
            PH_CHECK: begin
                n_phase             = PH_HUNT;
                n_len               = 8'd0;
                n_count             = 8'd0;
                n_check             = 8'd0;
                o_result.byte_role  = ROLE_CHECK;
                o_result.frame_end  = 1'b1;
                o_result.frame_good = (i_byte == r_check);
            end
            default: begin
                // Hunting, and any unused code, drops the byte unless it opens a frame.
                o_has_result = 1'b0;
                n_phase      = PH_HUNT;
                if (i_byte == i_start_byte) begin
                    n_phase = PH_LEN;
                    n_count = 8'd0;
                    n_check = 8'd0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= 8'd0;
            r_count <= 8'd0;
            r_check <= 8'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_count <= n_count;
            r_check <= n_check;
        end
    end

endmodule
